// ===== hdl/dptcm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-port TCM package
// Shared widths, codes and structures of the two-port tightly coupled memory.
// ----------------------------------------------------------------------------
package dptcm_pkg;

  // Memory geometry.
  localparam int WORD_COUNT = 8192;
  localparam int WORD_AW    = $clog2(WORD_COUNT);
  localparam int LANE_W     = 64;
  localparam int LANE_BYTES = LANE_W / 8;
  localparam int LOCAL_W    = WORD_AW + 3;

  // Field widths.
  localparam int OP_W     = 2;
  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 32;
  localparam int LEN_W    = 4;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int SIZE_W   = 17;
  localparam int LIMIT_W  = ADDR_W + 1;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_BASE_ADDRESS = 1'b0;
  localparam logic REG_REGION_SIZE  = 1'b1;
  localparam logic [ADDR_W-1:0] BASE_RESET = '0;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(65536);

  // Lane sizes of the two ports.
  localparam logic [LEN_W-1:0] DATA_LANE_BYTES  = LEN_W'(4);
  localparam logic [LEN_W-1:0] FETCH_LANE_BYTES = LEN_W'(8);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_DATA  = 2'd0;
  localparam logic [OP_W-1:0] OP_FETCH = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_TAKEN   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RSP     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_IDLE    = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ADDR_ERR = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CMD_ERR  = 2'd2;

  // Port indexes.
  localparam logic PORT_DATA  = 1'b0;
  localparam logic PORT_FETCH = 1'b1;

  // One input item as held in the input register.
  typedef struct packed {
    logic [OP_W-1:0]       operation;
    logic [CMD_W-1:0]      command;
    logic [ADDR_W-1:0]     address;
    logic [LANE_W-1:0]     write_data;
    logic [LEN_W-1:0]      data_length;
    logic [LEN_W-1:0]      enable_count;
    logic [LANE_BYTES-1:0] byte_enables;
  } item_t;

  // Region settings from the register block.
  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [LIMIT_W-1:0] limit;
    logic [LIMIT_W-1:0] word_limit;
  } cfg_t;

  // Memory access request.
  typedef struct packed {
    logic                  we;
    logic                  re;
    logic [WORD_AW-1:0]    addr;
    logic [LANE_W-1:0]     wdata;
    logic [LANE_BYTES-1:0] wbe;
  } ram_req_t;

  // Result description handed from the control stage to the output stage.
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic                port;
    logic [STATUS_W-1:0] status;
    logic                rd_ok;
    logic                upper;
    logic [LEN_W-1:0]    len;
  } meta_t;

endpackage

// ===== hdl/dptcm_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-port TCM request channel
// Valid/ready channel carrying one request or tick item.
// ----------------------------------------------------------------------------
interface dptcm_req_if
  import dptcm_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       operation;
  logic [CMD_W-1:0]      command;
  logic [ADDR_W-1:0]     address;
  logic [LANE_W-1:0]     write_data;
  logic [LEN_W-1:0]      data_length;
  logic [LEN_W-1:0]      enable_count;
  logic [LANE_BYTES-1:0] byte_enables;

  modport source (
    output valid, operation, command, address, write_data, data_length,
           enable_count, byte_enables,
    input  ready
  );

  modport sink (
    input  valid, operation, command, address, write_data, data_length,
           enable_count, byte_enables,
    output ready
  );
endinterface

// ===== hdl/dptcm_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-port TCM result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface dptcm_rsp_if
  import dptcm_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic                served_port;
  logic [STATUS_W-1:0] status;
  logic [LANE_W-1:0]   read_data;

  modport source (
    output valid, kind, served_port, status, read_data,
    input  ready
  );

  modport sink (
    input  valid, kind, served_port, status, read_data,
    output ready
  );
endinterface

// ===== hdl/dptcm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// Byte-writable memory with a registered read port and read enable.
// ----------------------------------------------------------------------------
module dptcm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [WIDTH/8-1:0]       wbe,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Byte-masked write and registered read; the read data holds between reads.
  always_ff @(posedge clk) begin
    for (int i = 0; i < WIDTH / 8; i++) begin
      if (we && wbe[i]) begin
        mem[addr][i*8 +: 8] <= wdata[i*8 +: 8];
      end
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== hdl/dptcm_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-port TCM region registers
// APB-style register block holding the region base and size.
// ----------------------------------------------------------------------------
module dptcm_regs
  import dptcm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [ADDR_W-1:0]  base_address;
  logic [SIZE_W-1:0]  region_size;
  logic [LIMIT_W-1:0] limit;
  logic [LIMIT_W-1:0] word_limit;
  logic               wr_en;
  logic               reg_sel;

  localparam logic [LIMIT_W-1:0] WORD_SPAN = LIMIT_W'(WORD_COUNT * 8);

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  // Register writes; the end-of-region bounds are kept precomputed.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= BASE_RESET;
      region_size  <= SIZE_RESET;
      limit        <= {1'b0, BASE_RESET} + LIMIT_W'(SIZE_RESET);
      word_limit   <= {1'b0, BASE_RESET} + WORD_SPAN;
    end else if (wr_en) begin
      case (reg_sel)
        REG_BASE_ADDRESS: begin
          base_address <= pwdata[ADDR_W-1:0];
          limit        <= {1'b0, pwdata[ADDR_W-1:0]} + LIMIT_W'(region_size);
          word_limit   <= {1'b0, pwdata[ADDR_W-1:0]} + WORD_SPAN;
        end
        REG_REGION_SIZE: begin
          region_size <= pwdata[SIZE_W-1:0];
          limit       <= {1'b0, base_address} + LIMIT_W'(pwdata[SIZE_W-1:0]);
        end
        default: begin
          region_size <= region_size;
        end
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (reg_sel)
      REG_BASE_ADDRESS: prdata = base_address;
      REG_REGION_SIZE:  prdata = PDATA_W'(region_size);
      default:          prdata = '0;
    endcase
  end

  assign cfg.base       = base_address;
  assign cfg.limit      = limit;
  assign cfg.word_limit = word_limit;

endmodule

// ===== hdl/dptcm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-port TCM control stage
// Request slots, fixed-priority service, region check and memory access.
// ----------------------------------------------------------------------------
module dptcm_ctrl
  import dptcm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     adv,
  input  logic     s0_valid,
  input  item_t    s0_item,
  input  cfg_t     cfg,
  output ram_req_t ram_req,
  output logic     s1_valid,
  output meta_t    s1_meta
);

  typedef struct packed {
    logic [CMD_W-1:0]      command;
    logic [ADDR_W-1:0]     address;
    logic [LANE_W-1:0]     write_data;
    logic [LEN_W-1:0]      length;
    logic [LEN_W-1:0]      enable_count;
    logic [LANE_BYTES-1:0] byte_enables;
  } slot_t;

  logic                  slot_valid [2];
  slot_t                 slots      [2];

  logic                  go;
  logic                  is_req;
  logic                  tick_hit;
  logic                  p_srv;
  logic                  sel;
  slot_t                 cur;
  logic                  in_region;
  logic [LOCAL_W-1:0]    region_offset;
  logic [LEN_W-1:0]      len;
  logic [LEN_W-1:0]      be_len;
  logic                  upper;
  logic [LANE_BYTES-1:0] on;
  logic [LANE_BYTES-1:0] strobe;
  meta_t                 meta_next;

  assign go       = adv && s0_valid;
  assign is_req   = (s0_item.operation == OP_DATA) || (s0_item.operation == OP_FETCH);
  assign tick_hit = (s0_item.operation == OP_TICK) && (slot_valid[0] || slot_valid[1]);
  assign p_srv    = slot_valid[0] ? PORT_DATA : PORT_FETCH;
  assign sel      = is_req ? s0_item.operation[0] : p_srv;
  assign cur      = slots[sel];

  // Region check against the precomputed bounds; all compares run in parallel.
  assign in_region = (cur.address >= cfg.base)
                  && ({1'b0, cur.address} < cfg.limit)
                  && ({1'b0, cur.address} < cfg.word_limit);
  assign region_offset = cur.address[LOCAL_W-1:0] - cfg.base[LOCAL_W-1:0];

  // Transfer length, lane half and byte strobe of the served slot.
  always_comb begin
    if (p_srv == PORT_DATA) begin
      len   = (cur.length > DATA_LANE_BYTES) ? DATA_LANE_BYTES : cur.length;
      upper = cur.address[2];
    end else begin
      len   = (cur.length > FETCH_LANE_BYTES) ? FETCH_LANE_BYTES : cur.length;
      upper = 1'b0;
    end
    be_len = (cur.enable_count > len) ? len : cur.enable_count;
    for (int i = 0; i < LANE_BYTES; i++) begin
      on[i] = (LEN_W'(i) < len)
           && ((be_len == '0) || ((LEN_W'(i) < be_len) && cur.byte_enables[i]));
    end
    strobe = upper ? {on[LANE_BYTES/2-1:0], (LANE_BYTES/2)'(0)} : on;
  end

  // Memory request for a served tick.
  always_comb begin
    ram_req.we    = go && tick_hit && in_region && (cur.command == CMD_WRITE);
    ram_req.re    = go && tick_hit && in_region && (cur.command == CMD_READ);
    ram_req.addr  = region_offset[LOCAL_W-1:3];
    ram_req.wdata = upper ? {cur.write_data[LANE_W/2-1:0], (LANE_W/2)'(0)}
                          : cur.write_data;
    ram_req.wbe   = strobe;
  end

  // Result description.
  always_comb begin
    meta_next.kind   = KIND_IDLE;
    meta_next.port   = PORT_DATA;
    meta_next.status = ST_OK;
    meta_next.rd_ok  = 1'b0;
    meta_next.upper  = upper;
    meta_next.len    = len;
    if (is_req) begin
      meta_next.kind = slot_valid[sel] ? KIND_REFUSED : KIND_TAKEN;
      meta_next.port = sel;
    end else if (tick_hit) begin
      meta_next.kind = KIND_RSP;
      meta_next.port = p_srv;
      if (!in_region) begin
        meta_next.status = ST_ADDR_ERR;
      end else if ((cur.command != CMD_READ) && (cur.command != CMD_WRITE)) begin
        meta_next.status = ST_CMD_ERR;
      end
      meta_next.rd_ok = in_region && (cur.command == CMD_READ);
    end
  end

  // Slot state and the stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid[0] <= 1'b0;
      slot_valid[1] <= 1'b0;
      slots[0]      <= '0;
      slots[1]      <= '0;
      s1_valid      <= 1'b0;
    end else if (adv) begin
      s1_valid <= s0_valid;
      if (s0_valid) begin
        s1_meta <= meta_next;
        if (is_req && !slot_valid[sel]) begin
          slot_valid[sel]          <= 1'b1;
          slots[sel].command       <= s0_item.command;
          slots[sel].address       <= s0_item.address;
          slots[sel].write_data    <= s0_item.write_data;
          slots[sel].length        <= s0_item.data_length;
          slots[sel].enable_count  <= s0_item.enable_count;
          slots[sel].byte_enables  <= s0_item.byte_enables;
        end else if (tick_hit) begin
          slot_valid[p_srv] <= 1'b0;
        end
      end
    end
  end

  // A tick with a pending data request serves it and leaves the fetch slot alone.
  a_data_first: assert property (@(posedge clk) disable iff (rst)
    (go && (s0_item.operation == OP_TICK) && slot_valid[0])
      |=> (!slot_valid[0] && (slot_valid[1] == $past(slot_valid[1]))))
    else $error("data slot not served first");

  // A memory write only comes from a successful write response.
  a_write_rsp: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |=> (s1_valid && (s1_meta.kind == KIND_RSP)
                    && (s1_meta.status == ST_OK) && !s1_meta.rd_ok))
    else $error("memory write without a matching response");

  // A request to a full slot is refused and keeps the slot full.
  a_refuse: assert property (@(posedge clk) disable iff (rst)
    (go && is_req && slot_valid[sel])
      |=> ((s1_meta.kind == KIND_REFUSED) && slot_valid[$past(sel)]))
    else $error("request to a full slot not refused");

  // Read data is only used for an error-free read response.
  a_read_ok: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_meta.rd_ok) |-> ((s1_meta.kind == KIND_RSP) && (s1_meta.status == ST_OK)))
    else $error("read data flagged on a non-read result");

endmodule

// ===== hdl/dptcm_fmt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-port TCM output stage
// Aligns and masks the read word and holds the result register.
// ----------------------------------------------------------------------------
module dptcm_fmt
  import dptcm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              s1_valid,
  input  meta_t             s1_meta,
  input  logic [LANE_W-1:0] ram_rdata,
  dptcm_rsp_if.source       rsp
);

  logic [LANE_W-1:0] word;
  logic [LANE_W-1:0] mask;
  logic [LANE_W-1:0] data_next;

  // Shift the selected half down and keep only the requested bytes.
  always_comb begin
    word = s1_meta.upper ? {(LANE_W/2)'(0), ram_rdata[LANE_W-1:LANE_W/2]} : ram_rdata;
    for (int i = 0; i < LANE_BYTES; i++) begin
      mask[i*8 +: 8] = (LEN_W'(i) < s1_meta.len) ? 8'hFF : 8'h00;
    end
    data_next = s1_meta.rd_ok ? (word & mask) : '0;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (adv) begin
      rsp.valid <= s1_valid;
      if (s1_valid) begin
        rsp.kind        <= s1_meta.kind;
        rsp.served_port <= s1_meta.port;
        rsp.status      <= s1_meta.status;
        rsp.read_data   <= data_next;
      end
    end
  end

endmodule

// ===== hdl/dual_port_tightly_coupled_memory.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-port tightly coupled memory
// Data and fetch request slots in front of one 64-bit word memory.
// ----------------------------------------------------------------------------
// A result passes the input register, the control and memory stage and the
// result register before it is offered. Throughput: one transaction per
// cycle while the result is not held; the single memory port serves one tick
// per cycle and the three stages advance together when the result moves.
// Reset clears the slots, the pipeline and the region registers (base 0,
// size 65536); memory contents are undefined until written and need no sweep.
module dual_port_tightly_coupled_memory
  import dptcm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  dptcm_req_if.sink          req,
  dptcm_rsp_if.source        rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic              adv;
  logic              s0_valid;
  item_t             s0_item;
  cfg_t              cfg;
  ram_req_t          ram_req;
  logic              s1_valid;
  meta_t             s1_meta;
  logic [LANE_W-1:0] ram_rdata;

  // The pipeline moves whenever the result register is empty or being taken.
  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= req.valid;
      if (req.valid) begin
        s0_item.operation    <= req.operation;
        s0_item.command      <= req.command;
        s0_item.address      <= req.address;
        s0_item.write_data   <= req.write_data;
        s0_item.data_length  <= req.data_length;
        s0_item.enable_count <= req.enable_count;
        s0_item.byte_enables <= req.byte_enables;
      end
    end
  end

  dptcm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dptcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .s0_valid (s0_valid),
    .s0_item  (s0_item),
    .cfg      (cfg),
    .ram_req  (ram_req),
    .s1_valid (s1_valid),
    .s1_meta  (s1_meta)
  );

  dptcm_ram #(
    .WIDTH (LANE_W),
    .DEPTH (WORD_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .re    (ram_req.re),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .wbe   (ram_req.wbe),
    .rdata (ram_rdata)
  );

  dptcm_fmt u_fmt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .s1_valid  (s1_valid),
    .s1_meta   (s1_meta),
    .ram_rdata (ram_rdata),
    .rsp       (rsp)
  );

endmodule

// ===== tb/dual_port_tightly_coupled_memory_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-port tightly coupled memory testbench
// Drives data and fetch requests and ticks into the memory, keeps its own
// model of the two request slots, the region registers and the word store,
// and compares every result with the model. Directed cases cover byte lanes,
// lengths, enables, port priority and error status. Random traffic then runs
// under several region settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module dual_port_tightly_coupled_memory_test;
  import dptcm_pkg::*;

  // Codes that the package leaves unnamed.
  localparam logic [OP_W-1:0]  OP_IDLE    = 2'd3;
  localparam logic [CMD_W-1:0] CMD_BAD_LO = 2'd2;
  localparam logic [CMD_W-1:0] CMD_BAD_HI = 2'd3;

  // Words that are fully written before any read may touch them.
  localparam int POOL_WORDS    = 16;
  localparam int SETTLE_CYCLES = 4;
  localparam int GAP_MAX       = 12;
  localparam logic [ADDR_W:0] ADDR_TOP = {1'b0, {ADDR_W{1'b1}}};

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic                port;
    logic [STATUS_W-1:0] status;
    logic [LANE_W-1:0]   data;
  } tcm_result_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  dptcm_req_if req_ch ();
  dptcm_rsp_if rsp_ch ();

  dual_port_tightly_coupled_memory dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Model state: word store, request slots and region registers.
  logic [LANE_W-1:0] tcm_words [WORD_COUNT];
  item_t             held_req [2];
  bit                held_valid [2];
  logic [ADDR_W-1:0] base_reg = BASE_RESET;
  logic [SIZE_W-1:0] size_reg = SIZE_RESET;

  tcm_result_t expected_results [$];
  bit quiet_link = 1'b0;
  int failures        = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int responses_seen  = 0;
  int refusals_seen   = 0;
  int settings_used   = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: ready drops in random bursts unless the link is quiet.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet_link && $urandom_range(0, 9) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  // First byte address past the region, computed without wrapping.
  function automatic logic [ADDR_W:0] region_limit();
    return {1'b0, base_reg} + (ADDR_W + 1)'(size_reg);
  endfunction

  function automatic int unsigned pool_index(input int unsigned k);
    return (k < POOL_WORDS / 2) ? k : WORD_COUNT - POOL_WORDS + k;
  endfunction

  // Serve the pending request of one port against the model store.
  function automatic void serve_held(input logic p, output logic [STATUS_W-1:0] st,
                                     output logic [LANE_W-1:0] rd);
    item_t             r;
    logic [ADDR_W-1:0] loc;
    int unsigned       idx, len, be_len, off;
    logic [7:0]        strobe;
    logic [LANE_W-1:0] val, mask;
    r = held_req[p];
    rd = '0;
    val = '0;
    mask = '0;
    strobe = '0;
    if (r.address < base_reg || {1'b0, r.address} >= region_limit()) begin
      st = ST_ADDR_ERR;
      return;
    end
    loc = r.address - base_reg;
    idx = loc >> 3;
    if (idx >= WORD_COUNT) begin
      st = ST_ADDR_ERR;
      return;
    end
    len = r.data_length;
    if (p == PORT_DATA) begin
      if (len > DATA_LANE_BYTES) len = DATA_LANE_BYTES;
      off = r.address[2] ? 4 : 0;
    end else begin
      if (len > FETCH_LANE_BYTES) len = FETCH_LANE_BYTES;
      off = 0;
    end
    if (r.command == CMD_WRITE) begin
      be_len = r.enable_count;
      if (be_len > len) be_len = len;
      for (int i = 0; i < len; i++) begin
        val[8*(off+i) +: 8] = r.write_data[8*i +: 8];
        if (be_len == 0 || (i < be_len && r.byte_enables[i])) strobe[off+i] = 1'b1;
      end
      for (int i = 0; i < LANE_BYTES; i++)
        if (strobe[i]) mask[8*i +: 8] = 8'hFF;
      tcm_words[idx] = (tcm_words[idx] & ~mask) | (val & mask);
      st = ST_OK;
    end else if (r.command == CMD_READ) begin
      for (int i = 0; i < len; i++) rd[8*i +: 8] = tcm_words[idx][8*(off+i) +: 8];
      st = ST_OK;
    end else begin
      st = ST_CMD_ERR;
    end
  endfunction

  // Expected result of one accepted item; updates the model state.
  function automatic tcm_result_t predict_result(input item_t it);
    tcm_result_t         r;
    logic                p;
    logic [STATUS_W-1:0] st;
    logic [LANE_W-1:0]   rd;
    r = '{kind: KIND_IDLE, port: PORT_DATA, status: ST_OK, data: '0};
    if (it.operation == OP_DATA || it.operation == OP_FETCH) begin
      p = (it.operation == OP_FETCH);
      r.port = p;
      if (held_valid[p]) begin
        r.kind = KIND_REFUSED;
      end else begin
        held_valid[p] = 1'b1;
        held_req[p] = it;
        r.kind = KIND_TAKEN;
      end
    end else if (it.operation == OP_TICK && (held_valid[PORT_DATA] || held_valid[PORT_FETCH])) begin
      p = held_valid[PORT_DATA] ? PORT_DATA : PORT_FETCH;
      serve_held(p, st, rd);
      held_valid[p] = 1'b0;
      r = '{kind: KIND_RSP, port: p, status: st, data: rd};
    end
    return r;
  endfunction

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    tcm_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d port %0d", rsp_ch.kind, rsp_ch.served_port);
        failures++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (want.kind == KIND_RSP) responses_seen++;
        if (want.kind == KIND_REFUSED) refusals_seen++;
        if (rsp_ch.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, rsp_ch.kind);
          failures++;
        end
        if (rsp_ch.served_port !== want.port) begin
          $error("served_port: expected %0d, actual %0d", want.port, rsp_ch.served_port);
          failures++;
        end
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
          failures++;
        end
        if (rsp_ch.read_data !== want.data) begin
          $error("read_data: expected %h, actual %h", want.data, rsp_ch.read_data);
          failures++;
        end
      end
    end
  end

  function automatic item_t make_item(input logic [OP_W-1:0] op, input logic [CMD_W-1:0] cmd,
                                      input logic [ADDR_W-1:0] addr,
                                      input logic [LANE_W-1:0] wdata,
                                      input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] ec,
                                      input logic [LANE_BYTES-1:0] be);
    item_t it;
    it.operation    = op;
    it.command      = cmd;
    it.address      = addr;
    it.write_data   = wdata;
    it.data_length  = len;
    it.enable_count = ec;
    it.byte_enables = be;
    return it;
  endfunction

  // An item with every field random except the operation.
  function automatic item_t noise_item(input logic [OP_W-1:0] op);
    return make_item(op, CMD_W'($urandom_range(0, 3)), ADDR_W'($urandom),
                     {$urandom, $urandom}, LEN_W'($urandom_range(0, 15)),
                     LEN_W'($urandom_range(0, 15)), LANE_BYTES'($urandom_range(0, 255)));
  endfunction

  // A random address outside the region, often right at its edges.
  function automatic logic [ADDR_W-1:0] outside_address();
    logic [ADDR_W-1:0] a;
    logic [ADDR_W:0]   lim;
    int unsigned       pick;
    lim = region_limit();
    pick = $urandom_range(0, 2);
    if (pick == 0 && lim <= ADDR_TOP) return lim[ADDR_W-1:0];
    if (pick == 1 && base_reg != '0) return base_reg - 1'b1;
    do a = $urandom; while (a >= base_reg && {1'b0, a} < lim);
    return a;
  endfunction

  // Shape a request's command, length and address; in-region reads only reach preloaded words.
  function automatic void shape_request(inout item_t it);
    logic            p;
    logic [ADDR_W:0] loc;
    bit              found;
    int unsigned     c;
    p = (it.operation == OP_FETCH);
    c = $urandom_range(0, 99);
    if (c < 45) it.command = CMD_READ;
    else if (c < 85) it.command = CMD_WRITE;
    else it.command = CMD_W'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
    if ($urandom_range(0, 9) < 7)
      it.data_length = LEN_W'($urandom_range(0, p ? FETCH_LANE_BYTES : DATA_LANE_BYTES));
    if ($urandom_range(0, 1) == 1)
      it.enable_count = LEN_W'($urandom_range(0, it.data_length));
    found = 1'b0;
    if ($urandom_range(0, 9) == 0) begin
      found = 1'b0;
    end else if (it.command == CMD_READ) begin
      for (int t = 0; t < 16 && !found; t++) begin
        loc = (ADDR_W + 1)'(8 * pool_index($urandom_range(0, POOL_WORDS - 1)) +
                            $urandom_range(0, 7));
        if (loc < (ADDR_W + 1)'(size_reg) && {1'b0, base_reg} + loc <= ADDR_TOP) begin
          it.address = base_reg + loc[ADDR_W-1:0];
          found = 1'b1;
        end
      end
    end else if (size_reg != '0) begin
      loc = (ADDR_W + 1)'($urandom_range(0, size_reg - 1));
      if ({1'b0, base_reg} + loc <= ADDR_TOP) begin
        it.address = base_reg + loc[ADDR_W-1:0];
        found = 1'b1;
      end
    end
    if (!found) it.address = outside_address();
  endfunction

  // Send one transaction, with an occasional gap before it.
  task automatic send_item(input item_t it);
    if (!quiet_link && $urandom_range(0, 7) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.operation    <= it.operation;
    req_ch.command      <= it.command;
    req_ch.address      <= it.address;
    req_ch.write_data   <= it.write_data;
    req_ch.data_length  <= it.data_length;
    req_ch.enable_count <= it.enable_count;
    req_ch.byte_enables <= it.byte_enables;
    do @(posedge clk); while (!req_ch.ready);
    expected_results.push_back(predict_result(it));
    items_sent++;
  endtask

  // A request followed by the tick that serves it.
  task automatic access(input logic [OP_W-1:0] op, input logic [CMD_W-1:0] cmd,
                        input logic [ADDR_W-1:0] addr, input logic [LANE_W-1:0] wdata,
                        input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] ec,
                        input logic [LANE_BYTES-1:0] be);
    send_item(make_item(op, cmd, addr, wdata, len, ec, be));
    send_item(noise_item(OP_TICK));
  endtask

  // Empty both slots, then wait for every result and let the design settle.
  task automatic settle_block();
    while (held_valid[PORT_DATA] || held_valid[PORT_FETCH]) send_item(noise_item(OP_TICK));
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup phase, access phase, then an idle phase on the bus.
  task automatic write_register(input logic reg_index, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({reg_index, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_index == REG_BASE_ADDRESS) base_reg = value;
    else size_reg = value[SIZE_W-1:0];
    @(posedge clk);
  endtask

  // Random traffic under one region setting.
  task automatic run_region(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size,
                            input int count);
    item_t       it;
    int unsigned pick;
    settle_block();
    write_register(REG_BASE_ADDRESS, base);
    write_register(REG_REGION_SIZE, PDATA_W'(size));
    settings_used++;
    repeat (count) begin
      it = noise_item(OP_TICK);
      pick = $urandom_range(0, 99);
      if (pick < 30) it.operation = OP_DATA;
      else if (pick < 56) it.operation = OP_FETCH;
      else if (pick < 96) it.operation = OP_TICK;
      else it.operation = OP_IDLE;
      if ((it.operation == OP_DATA || it.operation == OP_FETCH) &&
          !held_valid[it.operation == OP_FETCH])
        shape_request(it);
      send_item(it);
    end
    settle_block();
  endtask

  // Fill the words that reads may touch, under the reset region.
  task automatic test_preload_pool();
    write_register(REG_BASE_ADDRESS, BASE_RESET);
    write_register(REG_REGION_SIZE, PDATA_W'(SIZE_RESET));
    settings_used++;
    for (int k = 0; k < POOL_WORDS; k++)
      access(OP_FETCH, CMD_WRITE, ADDR_W'(8 * pool_index(k)), {$urandom, $urandom},
             FETCH_LANE_BYTES, '0, '1);
    settle_block();
  endtask

  // Lane halves, length caps, enable counts and zero lengths.
  task automatic test_byte_lanes();
    access(OP_DATA, CMD_WRITE, 32'd12, '1, DATA_LANE_BYTES, 4'd3, 8'b0000_0101);
    access(OP_DATA, CMD_READ, 32'd12, '0, 4'hF, '0, '0);
    access(OP_FETCH, CMD_WRITE, 32'd16, {$urandom, $urandom}, 4'hF, 4'hF, '1);
    access(OP_DATA, CMD_WRITE, 32'd16, '1, '0, '0, '0);
    access(OP_FETCH, CMD_READ, 32'd23, '0, '0, '0, '0);
    access(OP_DATA, CMD_WRITE, 32'd0, '1, 4'd2, 4'hF, 8'h02);
    access(OP_FETCH, CMD_READ, 32'd5, '0, FETCH_LANE_BYTES, '0, '0);
    settle_block();
  endtask

  // Data port wins over fetch; a full slot refuses; empty and idle ticks.
  task automatic test_port_priority();
    send_item(noise_item(OP_TICK));
    send_item(make_item(OP_FETCH, CMD_READ, 32'd24, '0, FETCH_LANE_BYTES, '0, '0));
    send_item(make_item(OP_DATA, CMD_READ, 32'd28, '0, DATA_LANE_BYTES, '0, '0));
    send_item(noise_item(OP_DATA));
    send_item(noise_item(OP_FETCH));
    send_item(noise_item(OP_IDLE));
    send_item(noise_item(OP_TICK));
    send_item(noise_item(OP_TICK));
    settle_block();
  endtask

  // Address errors take precedence over command errors.
  task automatic test_error_status();
    access(OP_DATA, CMD_READ, '1, '0, DATA_LANE_BYTES, '0, '0);
    access(OP_FETCH, CMD_BAD_HI, 32'd0, '1, FETCH_LANE_BYTES, '0, '1);
    access(OP_DATA, CMD_BAD_LO, 32'h0001_0000, '1, DATA_LANE_BYTES, '0, '1);
    access(OP_FETCH, CMD_WRITE, 32'h0000_FFFF, '1, 4'd1, '0, '0);
    settle_block();
  endtask

  // Random traffic across region settings, extremes among them.
  task automatic test_region_settings();
    run_region(32'hFFFF_0000, SIZE_RESET, 100);
    run_region(ADDR_W'($urandom), '1, 100);
    run_region(32'hFFFF_FFF8, '1, 60);
    run_region(ADDR_W'($urandom), '0, 40);
    run_region(ADDR_W'($urandom), SIZE_W'($urandom_range(1, 65536)), 100);
    run_region(32'h0000_0003, SIZE_W'(65531), 100);
  endtask

  // Closing stretch with no stalls on either side.
  task automatic test_steady_stream();
    quiet_link = 1'b1;
    run_region(BASE_RESET, SIZE_RESET, 120);
  endtask

  initial begin
    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.operation    <= OP_TICK;
    req_ch.command      <= CMD_READ;
    req_ch.address      <= '0;
    req_ch.write_data   <= '0;
    req_ch.data_length  <= '0;
    req_ch.enable_count <= '0;
    req_ch.byte_enables <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_preload_pool();
    test_byte_lanes();
    test_port_priority();
    test_error_status();
    test_region_settings();
    test_steady_stream();
    settle_block();

    $display("Sent %0d transactions under %0d region settings with stalls on both sides.",
             items_sent, settings_used);
    $display("Checked %0d results: %0d served responses, %0d refused requests.",
             results_checked, responses_seen, refusals_seen);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/dptcm_pkg.sv
hdl/dptcm_req_if.sv
hdl/dptcm_rsp_if.sv
hdl/dptcm_ram.sv
hdl/dptcm_regs.sv
hdl/dptcm_ctrl.sv
hdl/dptcm_fmt.sv
hdl/dual_port_tightly_coupled_memory.sv
tb/dual_port_tightly_coupled_memory_test.sv
